@@ rtl/core/point_in_polygon_test_defines.svh @@
// ---------------------------------------------------------------------------
// point_in_polygon_test_defines.svh
// Assertion macros used by the point-in-polygon RTL.
// ---------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// Same-cycle implication.
`define PIP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PIP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/pip_pkg.sv @@
// ---------------------------------------------------------------------------
// pip_pkg
// Mode codes and mode type of the point-in-polygon block.
// ---------------------------------------------------------------------------
package pip_pkg;

   localparam int MODE_W = 2;

   typedef logic [MODE_W-1:0] mode_type;

   localparam mode_type MODE_CLEAR  = 2'd0;
   localparam mode_type MODE_APPEND = 2'd1;
   localparam mode_type MODE_QUERY  = 2'd2;

endpackage

@@ rtl/core/pip_channel_if.sv @@
// ---------------------------------------------------------------------------
// pip_req_if / pip_rsp_if
// Valid/ready channels carrying request and response words.
// ---------------------------------------------------------------------------
interface pip_req_if #(
   parameter int COORD_BITS = 16
) ();
   import pip_pkg::*;

   logic                         valid;
   logic                         ready;
   mode_type                     mode;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;

   modport source (output valid, mode, coord_x, coord_y, input ready);
   modport sink   (input valid, mode, coord_x, coord_y, output ready);
endinterface

interface pip_rsp_if ();
   logic valid;
   logic ready;
   logic inside_res;
   logic status;

   modport source (output valid, inside_res, status, input ready);
   modport sink   (input valid, inside_res, status, output ready);
endinterface

@@ rtl/core/point_in_polygon_test.sv @@
// ---------------------------------------------------------------------------
// point_in_polygon_test
// Clear, append-vertex and ray-casting point query over a stored polygon.
// Clear, append and unused modes, and a query of an empty polygon: response
//   word registered at accept, one word per cycle while the response side drains.
// Query with n vertices: n+1 reads of the vertex RAM port plus three stages,
//   then the registered response word; no new word is taken until the walk
//   ends and the response is set; the single read port sets the walk length.
// Reset empties the polygon (vertex count to zero); the RAM is not cleared.
// ---------------------------------------------------------------------------
`include "point_in_polygon_test_defines.svh"

module point_in_polygon_test #(
   parameter int MAX_VERTICES = 256,
   parameter int COORD_BITS   = 16
) (
   input logic       clock,
   input logic       reset,
   pip_req_if.sink   req_ch,
   pip_rsp_if.source rsp_ch
);
   import pip_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int VW = 2 * CB;                      // stored vertex {y, x}
   localparam int AW = $clog2(MAX_VERTICES);        // RAM address
   localparam int CW = $clog2(MAX_VERTICES + 1);    // vertex count
   localparam int DW = CB + 1;                      // coordinate difference
   localparam int PW = 2 * DW;                      // product
   localparam int SW = PW + 1;                      // sum of two products
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN} state_type;

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   state_type     state_ff, state_in;
   logic [CW-1:0] vcnt_ff, vcnt_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_inside_ff, rsp_inside_in;
   logic          rsp_status_ff, rsp_status_in;
   logic          hit_ff, hit_in;            // point on some edge
   logic          par_ff, par_in;            // crossing parity

   // Pipeline tags: r = RAM data out, a = differences, b = products
   logic r_vld_ff, r_first_ff, r_last_ff;
   logic a_vld_ff, a_last_ff;
   logic b_vld_ff, b_last_ff;

   // ------------------------------------------------------------------
   // Datapath registers (no reset)
   // ------------------------------------------------------------------
   logic signed [CB-1:0] px_ff, py_ff;
   logic [VW-1:0]        prev_ff;           // edge start vertex
   logic [VW-1:0]        mem_q_ff;          // edge end vertex
   logic signed [DW-1:0] a_pax_ff, a_pay_ff, a_bax_ff, a_bay_ff, a_pbx_ff, a_pby_ff;
   logic                 a_sw_ff, a_band_ff;
   logic signed [PW-1:0] b_m1_ff, b_m2_ff, b_m3_ff, b_m4_ff;
   logic                 b_sw_ff, b_band_ff;

   logic [VW-1:0] vmem [MAX_VERTICES];

   // ------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------
   logic req_acc;
   // Items are taken in idle only; the response register may be emptying
   // in the same cycle, so back-to-back short words keep one per cycle while the response side takes them.
   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_acc      = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.inside_res = rsp_inside_ff;
   assign rsp_ch.status     = rsp_status_ff;

   // ------------------------------------------------------------------
   // Vertex RAM: one write (append), one registered read (walk).
   // Appends complete at accept and the walk starts in the cycle after its query is accepted, so a
   // read never overlaps a write to the same entry.
   // ------------------------------------------------------------------
   logic          mem_we;
   logic [AW-1:0] rd_addr;

   assign mem_we = req_acc && (req_ch.mode == MODE_APPEND) && (vcnt_ff < MAX_CNT);
   // Walk reads 0..n-1 and then 0 again for the closing edge.
   assign rd_addr = (rd_idx_ff == vcnt_ff) ? '0 : rd_idx_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vmem[vcnt_ff[AW-1:0]] <= {req_ch.coord_y, req_ch.coord_x};
      end
      mem_q_ff <= vmem[rd_addr];
   end

   // ------------------------------------------------------------------
   // Stage a: edge a = previous vertex, b = vertex just read
   // ------------------------------------------------------------------
   logic signed [CB-1:0] ax, ay, bx, by;
   logic                 swap_w, band_w;

   assign ax = $signed(prev_ff[CB-1:0]);
   assign ay = $signed(prev_ff[VW-1:CB]);
   assign bx = $signed(mem_q_ff[CB-1:0]);
   assign by = $signed(mem_q_ff[VW-1:CB]);

   assign swap_w = (ay > by);
   // Half-open band: low end < py <= high end
   assign band_w = swap_w ? ((py_ff > by) && (py_ff <= ay))
                          : ((py_ff > ay) && (py_ff <= by));

   // ------------------------------------------------------------------
   // Accumulate from stage b.
   // cr = cross(p-a, b-a); crossing test of the ordered edge equals cr > 0
   // when the endpoints were swapped, and cr < 0 otherwise.
   // ------------------------------------------------------------------
   logic signed [SW-1:0] cr_w, dt_w;
   logic                 on_edge_w, cross_w;

   assign cr_w      = SW'(b_m1_ff) - SW'(b_m2_ff);
   assign dt_w      = SW'(b_m3_ff) + SW'(b_m4_ff);
   assign on_edge_w = (cr_w == '0) && (dt_w[SW-1] || (dt_w == '0));
   assign cross_w   = b_band_ff && (b_sw_ff ? (!cr_w[SW-1] && (cr_w != '0))
                                            : cr_w[SW-1]);

   always_comb begin
      if (req_acc) begin
         hit_in = 1'b0;
         par_in = 1'b0;
      end else begin
         hit_in = hit_ff | (b_vld_ff & on_edge_w);
         par_in = par_ff ^ (b_vld_ff & cross_w);
      end
   end

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      vcnt_in       = vcnt_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_inside_in = rsp_inside_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               rsp_inside_in = 1'b0;
               rsp_status_in = 1'b0;
               unique case (req_ch.mode)
                  MODE_CLEAR: begin
                     vcnt_in      = '0;
                     rsp_valid_in = 1'b1;
                  end
                  MODE_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (vcnt_ff < MAX_CNT) begin
                        vcnt_in = vcnt_ff + CW'(1);
                     end else begin
                        rsp_status_in = 1'b1;   // store full, vertex dropped
                     end
                  end
                  MODE_QUERY: begin
                     rd_idx_in = '0;
                     if (vcnt_ff == '0) begin
                        rsp_valid_in = 1'b1;    // empty polygon: outside
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;       // unused mode: no effect
                  end
               endcase
            end
         end
         ST_WALK: begin
            rd_idx_in = rd_idx_ff + CW'(1);
            if (rd_idx_ff == vcnt_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (b_vld_ff && b_last_ff) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_inside_in = hit_in | par_in;
               rsp_status_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcnt_ff      <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         par_ff       <= 1'b0;
         r_vld_ff     <= 1'b0;
         r_first_ff   <= 1'b0;
         r_last_ff    <= 1'b0;
         a_vld_ff     <= 1'b0;
         a_last_ff    <= 1'b0;
         b_vld_ff     <= 1'b0;
         b_last_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcnt_ff      <= vcnt_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         par_ff       <= par_in;
         r_vld_ff     <= (state_ff == ST_WALK);
         r_first_ff   <= (rd_idx_ff == '0);
         r_last_ff    <= (rd_idx_ff == vcnt_ff);
         a_vld_ff     <= r_vld_ff && !r_first_ff;   // first read only seeds prev
         a_last_ff    <= r_last_ff;
         b_vld_ff     <= a_vld_ff;
         b_last_ff    <= a_last_ff;
      end
      rsp_inside_ff <= rsp_inside_in;
      rsp_status_ff <= rsp_status_in;
   end

   // ------------------------------------------------------------------
   // Datapath stages
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_acc) begin
         px_ff <= req_ch.coord_x;
         py_ff <= req_ch.coord_y;
      end
      if (r_vld_ff) begin
         prev_ff <= mem_q_ff;
      end
      a_pax_ff  <= DW'(px_ff) - DW'(ax);
      a_pay_ff  <= DW'(py_ff) - DW'(ay);
      a_bax_ff  <= DW'(bx) - DW'(ax);
      a_bay_ff  <= DW'(by) - DW'(ay);
      a_pbx_ff  <= DW'(px_ff) - DW'(bx);
      a_pby_ff  <= DW'(py_ff) - DW'(by);
      a_sw_ff   <= swap_w;
      a_band_ff <= band_w;
      b_m1_ff   <= a_pax_ff * a_bay_ff;
      b_m2_ff   <= a_pay_ff * a_bax_ff;
      b_m3_ff   <= a_pax_ff * a_pbx_ff;
      b_m4_ff   <= a_pay_ff * a_pby_ff;
      b_sw_ff   <= a_sw_ff;
      b_band_ff <= a_band_ff;
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `PIP_ASSERT_NOW(a_ready_idle, clock, reset, req_ch.ready, state_ff == ST_IDLE,
                   "ready outside idle")
   `PIP_ASSERT_NOW(a_cnt_max, clock, reset, 1'b1, vcnt_ff <= MAX_CNT,
                   "vertex count over capacity")
   `PIP_ASSERT_NOW(a_walk_idx, clock, reset, state_ff == ST_WALK,
                   (rd_idx_ff <= vcnt_ff) && (vcnt_ff != '0), "walk index out of range")
   `PIP_ASSERT_NOW(a_busy_no_rsp, clock, reset, state_ff != ST_IDLE, !rsp_valid_ff,
                   "response pending during walk")
   `PIP_ASSERT_NEXT(a_query_walk, clock, reset,
                    req_acc && (req_ch.mode == MODE_QUERY) && (vcnt_ff != '0),
                    state_ff == ST_WALK, "query did not start walk")
   `PIP_ASSERT_NEXT(a_drain_rsp, clock, reset,
                    (state_ff == ST_DRAIN) && b_vld_ff && b_last_ff,
                    rsp_valid_ff && (state_ff == ST_IDLE), "query end without response")

endmodule

@@ dv/point_in_polygon_test_tb.sv @@
// ---------------------------------------------------------------------------
// point_in_polygon_test_tb
// Self-checking bench for the ray-casting polygon block. Builds polygons
// word by word, queries points on vertices, edges, vertex rows and open
// space, and compares every response word against an in-bench predictor
// of the vertex store, with random gaps and stalls on both channels.
// ---------------------------------------------------------------------------
module point_in_polygon_test_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pip_pkg::*;

   localparam int MAX_VERTICES = 256;
   localparam int COORD_BITS   = 16;
   localparam int NUM_ITEMS    = 950;
   // Slowest legal word: query over a full store plus the longest gap and
   // stall on each side; this is several times that.
   localparam int STALL_LIMIT  = 4000;
   localparam int REPORT_MAX   = 10;

   // Mode 3 is not named in the package; the block treats it as a no-op.
   localparam mode_type MODE_UNUSED = 2'd3;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic in_poly;
      logic status;
   } answer_type;

   // Shadow of the vertex store plus the queue of answers still owed.
   class polygon_tracker_type;
      coord_type   vx [MAX_VERTICES];
      coord_type   vy [MAX_VERTICES];
      int unsigned n_vertices;
      answer_type  pending_answers [$];
      int unsigned mismatches;

      function new();
         n_vertices  = 0;
         mismatches  = 0;
      endfunction

      // Boundary hit wins; otherwise odd count of upward edges right of p.
      function bit point_in_polygon(longint px, longint py);
         longint      ax, ay, bx, by, cr, dt, t;
         int unsigned j;
         int unsigned crossings;
         crossings = 0;
         for (int unsigned i = 0; i < n_vertices; i++) begin
            j  = (i + 1 < n_vertices) ? i + 1 : 0;
            ax = vx[i];
            ay = vy[i];
            bx = vx[j];
            by = vy[j];
            if ((px == ax && py == ay) || (px == bx && py == by))
               return 1'b1;
            cr = (px - ax) * (by - ay) - (py - ay) * (bx - ax);
            dt = (px - ax) * (px - bx) + (py - ay) * (py - by);
            if (cr == 0 && dt <= 0)
               return 1'b1;
            if (ay > by) begin
               t = ax; ax = bx; bx = t;
               t = ay; ay = by; by = t;
            end
            if (py > ay && py <= by &&
                (bx - ax) * (py - ay) - (by - ay) * (px - ax) > 0)
               crossings++;
         end
         return crossings[0];
      endfunction

      function void note_request(mode_type m, coord_type x, coord_type y);
         answer_type a;
         a = '0;
         case (m)
            MODE_CLEAR: n_vertices = 0;
            MODE_APPEND: begin
               if (n_vertices < MAX_VERTICES) begin
                  vx[n_vertices] = x;
                  vy[n_vertices] = y;
                  n_vertices++;
               end else begin
                  a.status = 1'b1;
               end
            end
            MODE_QUERY: a.in_poly = point_in_polygon(x, y);
            default: ;
         endcase
         pending_answers.insert(pending_answers.size(), a);
      endfunction

      function void flag(string what, logic want, logic got);
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("%0t: %s mismatch, expected %0b, got %0b", $realtime, what, want, got);
      endfunction

      function void check_answer(logic in_poly, logic status);
         answer_type want;
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: response word with nothing pending (inside %0b status %0b)",
                        $realtime, in_poly, status);
            return;
         end
         want = pending_answers.pop_front();
         if (want.in_poly !== in_poly) flag("inside_res", want.in_poly, in_poly);
         if (want.status !== status) flag("status", want.status, status);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   pip_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
   pip_rsp_if rsp_ch ();

   point_in_polygon_test #(
      .MAX_VERTICES(MAX_VERTICES),
      .COORD_BITS  (COORD_BITS)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   polygon_tracker_type tracker;

   // calm = 1 gives stretches where neither side idles.
   bit calm = 1'b0;
   int items_sent = 0;
   int rsp_hold = 0;
   int quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog: any handshake on either channel resets the count.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("point_in_polygon_test_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response side: sample at the rising edge, draw a stall per word.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_answer(rsp_ch.inside_res, rsp_ch.status);
         rsp_hold = calm ? 0 : $urandom_range(0, 8);
      end
   end

   // Ready changes only at the falling edge.
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold = rsp_hold - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   // One request word: random gap, then hold valid until ready is seen.
   task automatic send_word(mode_type m, int x, int y);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.mode    <= m;
      req_ch.coord_x <= x[COORD_BITS-1:0];
      req_ch.coord_y <= y[COORD_BITS-1:0];
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_request(m, x[COORD_BITS-1:0], y[COORD_BITS-1:0]);
      items_sent++;
   endtask

   // Uniform integer in [-lim, lim].
   function automatic int pick(int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   function automatic int full_coord();
      return pick(32768) > 32767 ? 32767 : int'($urandom_range(0, 65535)) - 32768;
   endfunction

   // Query point aimed at the interesting places of the current polygon.
   task automatic query_near(int lim);
      int n, k, j, x, y;
      n = tracker.n_vertices;
      k = (n > 0) ? $urandom_range(0, n - 1) : 0;
      j = (k + 1 < n) ? k + 1 : 0;
      case (n > 0 ? $urandom_range(0, 4) : 1)
         0: begin                       // exactly on a vertex
            x = tracker.vx[k];
            y = tracker.vy[k];
         end
         1: begin                       // anywhere around the polygon
            x = pick(lim);
            y = pick(lim);
         end
         2: begin                       // edge midpoint, floored
            x = (int'(tracker.vx[k]) + int'(tracker.vx[j])) >>> 1;
            y = (int'(tracker.vy[k]) + int'(tracker.vy[j])) >>> 1;
         end
         3: begin                       // ray passes through a vertex row
            x = pick(lim);
            y = tracker.vy[k];
         end
         default: begin                 // anywhere in the coordinate space
            x = full_coord();
            y = full_coord();
         end
      endcase
      send_word(MODE_QUERY, x, y);
   endtask

   initial begin
      int grid, lim, n_append, n_query;
      tracker = new();
      req_ch.valid   = 1'b0;
      req_ch.mode    = MODE_CLEAR;
      req_ch.coord_x = '0;
      req_ch.coord_y = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      send_word(MODE_QUERY, 0, 0);                 // empty polygon
      send_word(MODE_UNUSED, -1, -1);              // unused mode, all ones
      send_word(MODE_APPEND, -32768, -32768);
      send_word(MODE_QUERY, -32768, -32768);       // single vertex hit
      send_word(MODE_QUERY, 0, 0);                 // single vertex miss
      send_word(MODE_APPEND, 32767, 32767);        // now a diagonal segment
      send_word(MODE_QUERY, 0, 0);                 // on the segment
      send_word(MODE_QUERY, 1, 0);                 // just off it
      send_word(MODE_QUERY, 32767, 32767);         // far end point
      send_word(MODE_CLEAR, 0, 0);
      send_word(MODE_APPEND, -32768, -32768);      // full-range square
      send_word(MODE_APPEND, 32767, -32768);
      send_word(MODE_APPEND, 32767, 32767);
      send_word(MODE_APPEND, -32768, 32767);
      send_word(MODE_QUERY, 0, 0);                 // interior
      send_word(MODE_QUERY, 32767, 0);             // right edge
      send_word(MODE_QUERY, -32768, 32767);        // corner
      send_word(MODE_QUERY, 0, -32768);            // bottom edge
      send_word(MODE_CLEAR, 0, 0);
      send_word(MODE_APPEND, 0, 0);                // small right triangle
      send_word(MODE_APPEND, 4, 0);
      send_word(MODE_APPEND, 0, 4);
      send_word(MODE_QUERY, 1, 1);                 // inside
      send_word(MODE_QUERY, 2, 2);                 // on the hypotenuse
      send_word(MODE_QUERY, 3, 3);                 // outside
      send_word(MODE_QUERY, -1, 0);                // outside, on a vertex row

      // ---- full store: fill, overflow, then query the largest polygon ----
      calm = 1'($urandom_range(0, 1));
      send_word(MODE_CLEAR, 0, 0);
      repeat (MAX_VERTICES) send_word(MODE_APPEND, pick(6), pick(6));
      repeat (3) send_word(MODE_APPEND, full_coord(), full_coord());
      repeat (4) query_near(8);

      // ---- random part: mostly clean build-and-query sequences ----
      while (items_sent < NUM_ITEMS) begin
         calm = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 99) < 85) begin
            if (tracker.n_vertices >= 48 || $urandom_range(0, 4) != 0)
               send_word(MODE_CLEAR, 0, 0);
            // small grids make edge and vertex hits common
            grid = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(2, 12);
            lim = (grid + 2 > 32767) ? 32767 : grid + 2;
            n_append = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                   : $urandom_range(1, 10);
            repeat (n_append) send_word(MODE_APPEND, pick(grid), pick(grid));
            n_query = $urandom_range(2, 8);
            repeat (n_query) query_near(lim);
         end else begin
            // noise: any mode, any coordinates
            repeat ($urandom_range(1, 4))
               send_word(mode_type'($urandom_range(0, 3)), full_coord(), full_coord());
         end
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;

      // Drain; every word yields exactly one response, so a short tail
      // catches anything extra.
      while (tracker.pending_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (tracker.mismatches == 0)
         $display("point_in_polygon_test_tb OK");
      else
         $display("point_in_polygon_test_tb NOT OK");
      $finish;
   end

endmodule
